[design/tph_pkg.sv]
// tph_pkg: shared constants, codes and types for the position histogram unit.
// Used by tph_axis_unit and tdc_position_histogram_unit.
`default_nettype none
package tph_pkg;

   // Fixed field widths
   localparam int NS_WIDTH        = 8;
   localparam int DELAY_WIDTH     = 10;
   localparam int SCALE_WIDTH     = 10;
   localparam int OFFSET_WIDTH    = DELAY_WIDTH + 1;
   localparam int POS_WIDTH       = 16;
   localparam int RSP_COUNT_WIDTH = 32;
   localparam int COL_IN_WIDTH    = 8;
   localparam int ROW_IN_WIDTH    = 6;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 10;

   // Opcodes
   localparam logic OP_EVENT = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NS_PER_COUNT    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DELAY_ENABLE    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LEFT_DELAY      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RIGHT_DELAY     = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOP_DELAY       = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BOTTOM_DELAY    = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DETECTOR_WIDTH  = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DETECTOR_HEIGHT = 3'd7;

   // Register reset values
   localparam logic [NS_WIDTH-1:0]    NS_RESET        = 8'd25;
   localparam logic [DELAY_WIDTH-1:0] LEFT_RESET      = 10'd40;
   localparam logic [DELAY_WIDTH-1:0] RIGHT_RESET     = 10'd20;
   localparam logic [DELAY_WIDTH-1:0] TOP_RESET       = 10'd10;
   localparam logic [DELAY_WIDTH-1:0] BOTTOM_RESET    = 10'd20;
   localparam logic [SCALE_WIDTH-1:0] WIDTH_RESET     = 10'd160;
   localparam logic [SCALE_WIDTH-1:0] HEIGHT_RESET    = 10'd60;

   // Status of one axis unit back to the sequencer
   typedef struct packed {
      logic                        done;
      logic                        zero_sum;
      logic signed [POS_WIDTH-1:0] pos;
   } axis_stat_type;

endpackage
`default_nettype wire

[design/tph_axis_unit.sv]
// tph_axis_unit: one axis position, bit-serial multiply, scale and long divide.
// Depends on tph_pkg.
`default_nettype none
module tph_axis_unit #(
   parameter int TIME_WIDTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   input  wire logic signed [TIME_WIDTH+1:0]           diff_op,
   input  wire logic signed [TIME_WIDTH+1:0]           sum_op,
   input  wire logic signed [tph_pkg::OFFSET_WIDTH-1:0] offset,
   input  wire logic [tph_pkg::NS_WIDTH-1:0]           ns,
   input  wire logic [tph_pkg::SCALE_WIDTH-1:0]        scale,
   output tph_pkg::axis_stat_type                      stat
);

   localparam int OW   = TIME_WIDTH + 2;
   localparam int DW   = TIME_WIDTH + 10;
   localparam int PW   = DW + tph_pkg::SCALE_WIDTH;
   localparam int NW   = PW + 4;
   localparam int QW   = tph_pkg::POS_WIDTH + 1;
   localparam int MW   = tph_pkg::SCALE_WIDTH;
   localparam int CNTW = $clog2(NW + 1);
   localparam logic [CNTW-1:0] MUL_LAST = CNTW'(tph_pkg::NS_WIDTH - 1);
   localparam logic [CNTW-1:0] SCL_LAST = CNTW'(tph_pkg::SCALE_WIDTH - 1);
   localparam logic [CNTW-1:0] DIV_LAST = CNTW'(NW - 1);
   localparam int PWD  = tph_pkg::POS_WIDTH;

   typedef enum logic [5:0] {
      A_IDLE = 6'b000001,
      A_MUL  = 6'b000010,
      A_ADJ  = 6'b000100,
      A_SCL  = 6'b001000,
      A_DIV  = 6'b010000,
      A_DONE = 6'b100000
   } astate_type;

   astate_type state_ff, state_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [MW-1:0]   mdig_ff, mdig_in;
   logic [DW-1:0]   dop_ff, dop_in, sop_ff, sop_in;
   logic [DW-1:0]   dacc_ff, dacc_in, sacc_ff, sacc_in;
   logic signed [tph_pkg::OFFSET_WIDTH-1:0] off_ff, off_in;
   logic [MW-1:0]   scale_ff, scale_in;
   logic            neg_ff, neg_in, zero_ff, zero_in;
   logic [PW-1:0]   mcand_ff, mcand_in;
   logic [NW-1:0]   num_ff, num_in;
   logic [DW-1:0]   rem_ff, rem_in;
   logic [QW-1:0]   q_ff, q_in;
   logic            ovf_ff, ovf_in;

   logic [DW-1:0]   adj_diff, dmag, smag;
   logic [DW:0]     trial, trial_sub;
   logic            trial_ge;
   logic [PWD-1:0]  pos_val;

   // Offset add and magnitudes
   assign adj_diff = dacc_ff + {{(DW-tph_pkg::OFFSET_WIDTH){off_ff[tph_pkg::OFFSET_WIDTH-1]}},
                                off_ff};
   assign dmag = adj_diff[DW-1] ? (~adj_diff + 1'b1) : adj_diff;
   assign smag = sacc_ff[DW-1] ? (~sacc_ff + 1'b1) : sacc_ff;

   // One restoring divide step
   assign trial     = {rem_ff, num_ff[NW-1]};
   assign trial_ge  = trial >= {1'b0, sacc_ff};
   assign trial_sub = trial - {1'b0, sacc_ff};

   // Sign and saturation of the quotient
   always_comb begin
      if (!neg_ff) begin
         if (ovf_ff || q_ff[QW-1] || q_ff[PWD-1]) pos_val = {1'b0, {(PWD-1){1'b1}}};
         else pos_val = q_ff[PWD-1:0];
      end else begin
         if (ovf_ff || q_ff[QW-1] || (q_ff[PWD-1] && (|q_ff[PWD-2:0])))
            pos_val = {1'b1, {(PWD-1){1'b0}}};
         else pos_val = ~q_ff[PWD-1:0] + 1'b1;
      end
   end

   assign stat = '{done: (state_ff == A_DONE), zero_sum: zero_ff, pos: pos_val};

   // Sequencer and data path
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      mdig_in  = mdig_ff;
      dop_in   = dop_ff;
      sop_in   = sop_ff;
      dacc_in  = dacc_ff;
      sacc_in  = sacc_ff;
      off_in   = off_ff;
      scale_in = scale_ff;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      mcand_in = mcand_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      ovf_in   = ovf_ff;
      case (state_ff)
         A_IDLE: begin
            if (start) begin
               dop_in   = {{(DW-OW){diff_op[OW-1]}}, diff_op};
               sop_in   = {{(DW-OW){sum_op[OW-1]}}, sum_op};
               dacc_in  = '0;
               sacc_in  = '0;
               mdig_in  = MW'(ns);
               off_in   = offset;
               scale_in = scale;
               cnt_in   = '0;
               state_in = A_MUL;
            end
         end
         A_MUL: begin
            // ns_per_count times both operands, one bit a cycle
            if (mdig_ff[0]) begin
               dacc_in = dacc_ff + dop_ff;
               sacc_in = sacc_ff + sop_ff;
            end
            dop_in  = {dop_ff[DW-2:0], 1'b0};
            sop_in  = {sop_ff[DW-2:0], 1'b0};
            mdig_in = {1'b0, mdig_ff[MW-1:1]};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) state_in = A_ADJ;
         end
         A_ADJ: begin
            neg_in   = adj_diff[DW-1] ^ sacc_ff[DW-1];
            zero_in  = (sacc_ff == '0);
            mcand_in = PW'(dmag);
            sacc_in  = smag;
            num_in   = '0;
            mdig_in  = scale_ff;
            cnt_in   = '0;
            state_in = A_SCL;
         end
         A_SCL: begin
            // |diff| times detector size, times 16 by placement
            if (mdig_ff[0]) num_in = num_ff + {mcand_ff, 4'b0000};
            mcand_in = {mcand_ff[PW-2:0], 1'b0};
            mdig_in  = {1'b0, mdig_ff[MW-1:1]};
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == SCL_LAST) begin
               rem_in   = '0;
               q_in     = '0;
               ovf_in   = 1'b0;
               cnt_in   = '0;
               state_in = A_DIV;
            end
         end
         A_DIV: begin
            // one quotient bit a cycle; bits above the window are sticky overflow
            rem_in = trial_ge ? trial_sub[DW-1:0] : trial[DW-1:0];
            q_in   = {q_ff[QW-2:0], trial_ge};
            ovf_in = ovf_ff | q_ff[QW-1];
            num_in = {num_ff[NW-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) state_in = A_DONE;
         end
         A_DONE: state_in = A_IDLE;
         default: state_in = A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      mdig_ff  <= mdig_in;
      dop_ff   <= dop_in;
      sop_ff   <= sop_in;
      dacc_ff  <= dacc_in;
      sacc_ff  <= sacc_in;
      off_ff   <= off_in;
      scale_ff <= scale_in;
      neg_ff   <= neg_in;
      zero_ff  <= zero_in;
      mcand_ff <= mcand_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      q_ff     <= q_in;
      ovf_ff   <= ovf_in;
   end

endmodule
`default_nettype wire

[design/tph_hist_mem.sv]
// tph_hist_mem: histogram count memory, one write and one registered read port,
// with a clearing pass after reset. No package dependencies.
`default_nettype none
module tph_hist_mem #(
   parameter int DEPTH = 9600,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic                          busy
);

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;
   logic [AW-1:0]    clr_ff, clr_in;
   logic             busy_ff, busy_in;

   // Clearing pass counter
   always_comb begin
      clr_in  = clr_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == LAST) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         busy_ff <= 1'b1;
      end else begin
         clr_ff  <= clr_in;
         busy_ff <= busy_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (busy_ff) mem[clr_ff] <= '0;
      else if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule
`default_nettype wire

[design/tdc_position_histogram_unit.sv]
// tdc_position_histogram_unit: delay-line 2D position and histogram top level.
// Depends on tph_pkg, tph_axis_unit and tph_hist_mem.
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | opcode, five TDC times, read bin
//   rsp     | out       | rsp_valid/rsp_stall | flags, x/y position, bin count
//   csr     | in        | csr_we              | csr_index, csr_wdata
//
// A new item is accepted only once the last is handed to the rsp register. For a
// counted event both axes run side by side through a bit-serial multiply by
// ns_per_count, an adjust step, a bit-serial scale, a long divide and a done state,
// then read, update and output; an event not counted skips read and update, as do
// an incomplete event and an out-of-range read; a bin read takes read, update and
// output. After reset the memory is cleared with req_stall high. A finished item
// waits in the rsp register while the next item is accepted.
`default_nettype none
module tdc_position_histogram_unit #(
   parameter int X_BINS      = 160,
   parameter int Y_BINS      = 60,
   parameter int COUNT_WIDTH = 32,
   parameter int TIME_WIDTH  = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic                                   req_opcode,
   input  wire logic [TIME_WIDTH-1:0]                  req_anode_time,
   input  wire logic [TIME_WIDTH-1:0]                  req_bottom_time,
   input  wire logic [TIME_WIDTH-1:0]                  req_right_time,
   input  wire logic [TIME_WIDTH-1:0]                  req_left_time,
   input  wire logic [TIME_WIDTH-1:0]                  req_top_time,
   input  wire logic [tph_pkg::COL_IN_WIDTH-1:0]       req_read_column,
   input  wire logic [tph_pkg::ROW_IN_WIDTH-1:0]       req_read_row,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic                                        rsp_event_complete,
   output logic                                        rsp_zero_sum,
   output logic signed [tph_pkg::POS_WIDTH-1:0]        rsp_x_position,
   output logic signed [tph_pkg::POS_WIDTH-1:0]        rsp_y_position,
   output logic                                        rsp_counted,
   output logic [tph_pkg::RSP_COUNT_WIDTH-1:0]         rsp_bin_count,
   input  wire logic                                   csr_we,
   input  wire logic [tph_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [tph_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);

   localparam int NBINS = X_BINS * Y_BINS;
   localparam int AW    = $clog2(NBINS);
   localparam int CW    = $clog2(X_BINS);
   localparam int RW    = $clog2(Y_BINS);
   localparam int OW    = TIME_WIDTH + 2;
   localparam int BW    = tph_pkg::POS_WIDTH + 2;
   localparam int PWD   = tph_pkg::POS_WIDTH;
   localparam int RCW   = tph_pkg::RSP_COUNT_WIDTH;
   localparam logic signed [BW-1:0] X_OFF = BW'(8 * X_BINS);
   localparam logic signed [BW-1:0] Y_OFF = BW'(8 * Y_BINS);
   localparam logic signed [BW-1:0] X_LIM = BW'(16 * X_BINS);
   localparam logic signed [BW-1:0] Y_LIM = BW'(16 * Y_BINS);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_AXIS = 5'b00010,
      S_RD   = 5'b00100,
      S_UPD  = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   // Configuration registers
   logic [tph_pkg::NS_WIDTH-1:0]    ns_ff;
   logic                            den_ff;
   logic [tph_pkg::DELAY_WIDTH-1:0] left_ff, right_ff, top_ff, bottom_ff;
   logic [tph_pkg::SCALE_WIDTH-1:0] width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ns_ff     <= tph_pkg::NS_RESET;
         den_ff    <= 1'b0;
         left_ff   <= tph_pkg::LEFT_RESET;
         right_ff  <= tph_pkg::RIGHT_RESET;
         top_ff    <= tph_pkg::TOP_RESET;
         bottom_ff <= tph_pkg::BOTTOM_RESET;
         width_ff  <= tph_pkg::WIDTH_RESET;
         height_ff <= tph_pkg::HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            tph_pkg::CSR_NS_PER_COUNT:    ns_ff     <= csr_wdata[tph_pkg::NS_WIDTH-1:0];
            tph_pkg::CSR_DELAY_ENABLE:    den_ff    <= csr_wdata[0];
            tph_pkg::CSR_LEFT_DELAY:      left_ff   <= csr_wdata;
            tph_pkg::CSR_RIGHT_DELAY:     right_ff  <= csr_wdata;
            tph_pkg::CSR_TOP_DELAY:       top_ff    <= csr_wdata;
            tph_pkg::CSR_BOTTOM_DELAY:    bottom_ff <= csr_wdata;
            tph_pkg::CSR_DETECTOR_WIDTH:  width_ff  <= csr_wdata;
            tph_pkg::CSR_DETECTOR_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Axis operands, formed from the item at accept
   logic signed [OW-1:0] x_diff_op, x_sum_op, y_diff_op, y_sum_op;
   logic signed [tph_pkg::OFFSET_WIDTH-1:0] x_offset, y_offset;
   logic complete, axis_start;
   tph_pkg::axis_stat_type x_stat, y_stat;

   assign x_diff_op = OW'(req_left_time) - OW'(req_right_time);
   assign y_diff_op = OW'(req_bottom_time) - OW'(req_top_time);
   assign x_sum_op  = OW'(req_left_time) + OW'(req_right_time) - (OW'(req_anode_time) << 1);
   assign y_sum_op  = OW'(req_bottom_time) + OW'(req_top_time) - (OW'(req_anode_time) << 1);
   assign x_offset  = den_ff ? (tph_pkg::OFFSET_WIDTH'(left_ff)
                                - tph_pkg::OFFSET_WIDTH'(right_ff)) : '0;
   assign y_offset  = den_ff ? (tph_pkg::OFFSET_WIDTH'(bottom_ff)
                                - tph_pkg::OFFSET_WIDTH'(top_ff)) : '0;
   assign complete  = (req_anode_time != '0) && (req_bottom_time != '0) &&
                      (req_right_time != '0) && (req_left_time != '0) &&
                      (req_top_time != '0);

   tph_axis_unit #(.TIME_WIDTH(TIME_WIDTH)) u_x_axis (
      .clock(clock), .reset(reset), .start(axis_start),
      .diff_op(x_diff_op), .sum_op(x_sum_op), .offset(x_offset),
      .ns(ns_ff), .scale(width_ff), .stat(x_stat)
   );

   tph_axis_unit #(.TIME_WIDTH(TIME_WIDTH)) u_y_axis (
      .clock(clock), .reset(reset), .start(axis_start),
      .diff_op(y_diff_op), .sum_op(y_sum_op), .offset(y_offset),
      .ns(ns_ff), .scale(height_ff), .stat(y_stat)
   );

   // Histogram memory
   logic                   mem_rd_en, mem_wr_en, mem_busy;
   logic [COUNT_WIDTH-1:0] mem_rd_data, mem_wr_data;
   logic [AW-1:0]          addr_ff, addr_in;

   tph_hist_mem #(.DEPTH(NBINS), .WIDTH(COUNT_WIDTH)) u_mem (
      .clock(clock), .reset(reset),
      .rd_en(mem_rd_en), .rd_addr(addr_ff), .rd_data(mem_rd_data),
      .wr_en(mem_wr_en), .wr_addr(addr_ff), .wr_data(mem_wr_data),
      .busy(mem_busy)
   );

   // Binning of the finished position
   logic signed [BW-1:0] sx, sy;
   logic in_window, read_in_range;
   logic [CW-1:0] ev_col;
   logic [RW-1:0] ev_row;

   assign sx = BW'(x_stat.pos) + X_OFF;
   assign sy = BW'(y_stat.pos) + Y_OFF;
   assign in_window = (sx >= 0) && (sx < X_LIM) && (sy >= 0) && (sy < Y_LIM);
   assign ev_col = sx[CW+3:4];
   assign ev_row = sy[RW+3:4];
   assign read_in_range = (32'(req_read_column) < X_BINS) && (32'(req_read_row) < Y_BINS);

   // Sequencer and result staging
   state_type state_ff, state_in;
   logic incr_ff, incr_in;
   logic ec_ff, ec_in, zs_ff, zs_in, cnt_flag_ff, cnt_flag_in;
   logic signed [PWD-1:0] xp_ff, xp_in, yp_ff, yp_in;
   logic [RCW-1:0] bc_ff, bc_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_ec_ff, rsp_ec_in, rsp_zs_ff, rsp_zs_in, rsp_cnt_ff, rsp_cnt_in;
   logic signed [PWD-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [RCW-1:0] rsp_bc_ff, rsp_bc_in;

   assign req_stall = (state_ff != S_IDLE) || mem_busy;

   always_comb begin
      state_in     = state_ff;
      incr_in      = incr_ff;
      addr_in      = addr_ff;
      ec_in        = ec_ff;
      zs_in        = zs_ff;
      cnt_flag_in  = cnt_flag_ff;
      xp_in        = xp_ff;
      yp_in        = yp_ff;
      bc_in        = bc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ec_in    = rsp_ec_ff;
      rsp_zs_in    = rsp_zs_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_bc_in    = rsp_bc_ff;
      mem_rd_en    = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_data  = (mem_rd_data == '1) ? mem_rd_data : mem_rd_data + 1'b1;
      axis_start   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !mem_busy) begin
               ec_in       = 1'b0;
               zs_in       = 1'b0;
               cnt_flag_in = 1'b0;
               xp_in       = '0;
               yp_in       = '0;
               bc_in       = '0;
               incr_in     = 1'b0;
               if (req_opcode == tph_pkg::OP_READ) begin
                  if (read_in_range) begin
                     addr_in  = AW'(32'(req_read_row) * X_BINS + 32'(req_read_column));
                     state_in = S_RD;
                  end else begin
                     state_in = S_OUT;
                  end
               end else if (complete) begin
                  axis_start = 1'b1;
                  state_in   = S_AXIS;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_AXIS: begin
            if (x_stat.done) begin
               ec_in = 1'b1;
               if (x_stat.zero_sum || y_stat.zero_sum) begin
                  zs_in    = 1'b1;
                  state_in = S_OUT;
               end else begin
                  xp_in = x_stat.pos;
                  yp_in = y_stat.pos;
                  if (in_window) begin
                     addr_in  = AW'(AW'(ev_row) * AW'(X_BINS)) + AW'(ev_col);
                     incr_in  = 1'b1;
                     state_in = S_RD;
                  end else begin
                     state_in = S_OUT;
                  end
               end
            end
         end
         S_RD: begin
            mem_rd_en = 1'b1;
            state_in  = S_UPD;
         end
         S_UPD: begin
            // saturating increment for events, plain read otherwise
            if (incr_ff) begin
               mem_wr_en   = 1'b1;
               cnt_flag_in = 1'b1;
               bc_in       = RCW'(mem_wr_data);
            end else begin
               bc_in = RCW'(mem_rd_data);
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_ec_in    = ec_ff;
               rsp_zs_in    = zs_ff;
               rsp_cnt_in   = cnt_flag_ff;
               rsp_x_in     = xp_ff;
               rsp_y_in     = yp_ff;
               rsp_bc_in    = bc_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      incr_ff     <= incr_in;
      addr_ff     <= addr_in;
      ec_ff       <= ec_in;
      zs_ff       <= zs_in;
      cnt_flag_ff <= cnt_flag_in;
      xp_ff       <= xp_in;
      yp_ff       <= yp_in;
      bc_ff       <= bc_in;
      rsp_ec_ff   <= rsp_ec_in;
      rsp_zs_ff   <= rsp_zs_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_bc_ff   <= rsp_bc_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_complete = rsp_ec_ff;
   assign rsp_zero_sum       = rsp_zs_ff;
   assign rsp_counted        = rsp_cnt_ff;
   assign rsp_x_position     = rsp_x_ff;
   assign rsp_y_position     = rsp_y_ff;
   assign rsp_bin_count      = rsp_bc_ff;

   // Checks
   a_axes_lockstep: assert property (@(posedge clock) disable iff (reset)
      x_stat.done == y_stat.done)
      else $error("axis units out of step");

   a_counted_event: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_counted) |-> (rsp_event_complete && !rsp_zero_sum))
      else $error("counted item without a complete nonzero-sum event");

   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> $past(mem_rd_en))
      else $error("histogram write without preceding read");

endmodule
`default_nettype wire
